FILE: hw/rtl/conv2d_forward_mac_core_assert.svh
// ----------------------------------------------------------------------------
// conv2d_forward_mac_core assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef CONV2D_FORWARD_MAC_CORE_ASSERT_SVH
`define CONV2D_FORWARD_MAC_CORE_ASSERT_SVH

// checked outside reset
`define CFM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CFM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/cfm_pkg.sv
// ----------------------------------------------------------------------------
// cfm_pkg
// Sizes, register map, modes and shared types of the convolution MAC core.
// ----------------------------------------------------------------------------
package cfm_pkg;

   localparam int MAX_SIDE     = 32;
   localparam int MAX_CHANNELS = 16;
   localparam int MAX_KERNEL   = 7;
   localparam int MAX_FILTERS  = 16;

   localparam int ACT_DEPTH = MAX_CHANNELS * MAX_SIDE * MAX_SIDE;
   localparam int WGT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int ACT_AW    = $clog2(ACT_DEPTH);
   localparam int WGT_AW    = $clog2(WGT_DEPTH);

   localparam int ACC_W = 42;

   // register map
   localparam logic [2:0] REG_IN_ROWS      = 3'd0;
   localparam logic [2:0] REG_IN_COLS      = 3'd1;
   localparam logic [2:0] REG_IN_DEPTH     = 3'd2;
   localparam logic [2:0] REG_KERNEL_ROWS  = 3'd3;
   localparam logic [2:0] REG_KERNEL_COLS  = 3'd4;
   localparam logic [2:0] REG_FILTER_COUNT = 3'd5;
   localparam logic [2:0] REG_STRIDE       = 3'd6;
   localparam logic [2:0] REG_PADDING      = 3'd7;

   localparam int CSR_AW = 5;

   // request modes
   localparam logic [1:0] MODE_WGT = 2'd0;
   localparam logic [1:0] MODE_ACT = 2'd1;
   localparam logic [1:0] MODE_RUN = 2'd2;

   // clamped configuration and derived output plane size
   typedef struct packed {
      logic [5:0] rows;
      logic [5:0] cols;
      logic [4:0] depth;
      logic [2:0] krows;
      logic [2:0] kcols;
      logic [4:0] nfilt;
      logic [2:0] stride;
      logic [1:0] pad;
      logic [5:0] orows;
      logic [5:0] ocols;
   } cfg_type;

   // store access, one port per memory
   typedef struct packed {
      logic              act_we;
      logic              wgt_we;
      logic              rd_en;
      logic [ACT_AW-1:0] act_addr;
      logic [WGT_AW-1:0] wgt_addr;
      logic [15:0]       wdata;
   } mem_req_type;

   // x / st for st in 1..4 without a divider
   function automatic logic [5:0] div_stride(input logic [5:0] x, input logic [2:0] st);
      logic [12:0] p;
      p = {7'd0, x} * 13'd43;
      case (st)
         3'd2:    return {1'b0, x[5:1]};
         3'd3:    return p[12:7];
         3'd4:    return {2'b00, x[5:2]};
         default: return x;
      endcase
   endfunction

endpackage

FILE: hw/rtl/cfm_if.sv
// ----------------------------------------------------------------------------
// cfm_req_if / cfm_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface cfm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [3:0]         filter_index;
   logic [3:0]         channel;
   logic [5:0]         row;
   logic [5:0]         col;
   logic signed [15:0] value;

   modport source (output valid, mode, filter_index, channel, row, col, value, input ready);
   modport sink   (input valid, mode, filter_index, channel, row, col, value, output ready);
endinterface

interface cfm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result;
   logic               accepted;

   modport source (output valid, result, accepted, input ready);
   modport sink   (input valid, result, accepted, output ready);
endinterface

FILE: hw/rtl/cfm_csr.sv
// ----------------------------------------------------------------------------
// cfm_csr
// APB register file, clamping and output plane size.
// ----------------------------------------------------------------------------
module cfm_csr
   import cfm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output cfg_type           cfg
);

   logic [5:0] in_rows_ff, in_cols_ff;
   logic [4:0] in_depth_ff, filter_count_ff;
   logic [2:0] kernel_rows_ff, kernel_cols_ff, stride_ff;
   logic [1:0] padding_ff;
   logic [2:0] idx;
   logic       wr;
   logic [6:0] span_r, span_c;

   assign idx = paddr[4:2];
   assign wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rows_ff      <= 6'd28;
         in_cols_ff      <= 6'd28;
         in_depth_ff     <= 5'd1;
         kernel_rows_ff  <= 3'd5;
         kernel_cols_ff  <= 3'd5;
         filter_count_ff <= 5'd1;
         stride_ff       <= 3'd1;
         padding_ff      <= 2'd0;
      end else if (wr) begin
         case (idx)
            REG_IN_ROWS:      in_rows_ff      <= pwdata[5:0];
            REG_IN_COLS:      in_cols_ff      <= pwdata[5:0];
            REG_IN_DEPTH:     in_depth_ff     <= pwdata[4:0];
            REG_KERNEL_ROWS:  kernel_rows_ff  <= pwdata[2:0];
            REG_KERNEL_COLS:  kernel_cols_ff  <= pwdata[2:0];
            REG_FILTER_COUNT: filter_count_ff <= pwdata[4:0];
            REG_STRIDE:       stride_ff       <= pwdata[2:0];
            REG_PADDING:      padding_ff      <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_IN_ROWS:      prdata = {26'd0, in_rows_ff};
         REG_IN_COLS:      prdata = {26'd0, in_cols_ff};
         REG_IN_DEPTH:     prdata = {27'd0, in_depth_ff};
         REG_KERNEL_ROWS:  prdata = {29'd0, kernel_rows_ff};
         REG_KERNEL_COLS:  prdata = {29'd0, kernel_cols_ff};
         REG_FILTER_COUNT: prdata = {27'd0, filter_count_ff};
         REG_STRIDE:       prdata = {29'd0, stride_ff};
         REG_PADDING:      prdata = {30'd0, padding_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // zero reads as one, too large reads as the maximum; padding is not clamped
   always_comb begin
      cfg.rows   = (in_rows_ff == 6'd0) ? 6'd1 :
                   (in_rows_ff > 6'(MAX_SIDE)) ? 6'(MAX_SIDE) : in_rows_ff;
      cfg.cols   = (in_cols_ff == 6'd0) ? 6'd1 :
                   (in_cols_ff > 6'(MAX_SIDE)) ? 6'(MAX_SIDE) : in_cols_ff;
      cfg.depth  = (in_depth_ff == 5'd0) ? 5'd1 :
                   (in_depth_ff > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : in_depth_ff;
      cfg.krows  = (kernel_rows_ff == 3'd0) ? 3'd1 :
                   (kernel_rows_ff > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kernel_rows_ff;
      cfg.kcols  = (kernel_cols_ff == 3'd0) ? 3'd1 :
                   (kernel_cols_ff > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kernel_cols_ff;
      cfg.nfilt  = (filter_count_ff == 5'd0) ? 5'd1 :
                   (filter_count_ff > 5'(MAX_FILTERS)) ? 5'(MAX_FILTERS) : filter_count_ff;
      cfg.stride = (stride_ff == 3'd0) ? 3'd1 : (stride_ff > 3'd4) ? 3'd4 : stride_ff;
      cfg.pad    = padding_ff;

      span_r = {1'b0, cfg.rows} + {4'd0, cfg.pad, 1'b0};
      span_c = {1'b0, cfg.cols} + {4'd0, cfg.pad, 1'b0};
      cfg.orows = (span_r < {4'd0, cfg.krows}) ? 6'd0 :
                  6'(7'd1 + {1'b0, div_stride(6'(span_r - {4'd0, cfg.krows}), cfg.stride)});
      cfg.ocols = (span_c < {4'd0, cfg.kcols}) ? 6'd0 :
                  6'(7'd1 + {1'b0, div_stride(6'(span_c - {4'd0, cfg.kcols}), cfg.stride)});
   end

endmodule

FILE: hw/rtl/cfm_store.sv
// ----------------------------------------------------------------------------
// cfm_store
// Activation and weight memories, one port each, registered read data.
// ----------------------------------------------------------------------------
module cfm_store
   import cfm_pkg::*;
(
   input  logic               clock,
   input  mem_req_type        mem,
   output logic signed [15:0] act_q,
   output logic signed [15:0] wgt_q
);

   logic [15:0] act_mem [ACT_DEPTH];
   logic [15:0] wgt_mem [WGT_DEPTH];
   logic [15:0] act_q_ff, wgt_q_ff;

   always_ff @(posedge clock) begin
      if (mem.act_we)
         act_mem[mem.act_addr] <= mem.wdata;
      if (mem.rd_en)
         act_q_ff <= act_mem[mem.act_addr];
   end

   always_ff @(posedge clock) begin
      if (mem.wgt_we)
         wgt_mem[mem.wgt_addr] <= mem.wdata;
      if (mem.rd_en)
         wgt_q_ff <= wgt_mem[mem.wgt_addr];
   end

   assign act_q = $signed(act_q_ff);
   assign wgt_q = $signed(wgt_q_ff);

endmodule

FILE: hw/rtl/cfm_seq.sv
// ----------------------------------------------------------------------------
// cfm_seq
// Request sequencer: store writes, kernel walk, multiply-accumulate, result.
// ----------------------------------------------------------------------------
module cfm_seq
   import cfm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   cfm_req_if.sink            req,
   cfm_rsp_if.source          rsp,
   output mem_req_type        mem,
   input  logic signed [15:0] act_q,
   input  logic signed [15:0] wgt_q
);

   typedef enum logic [1:0] {IDLE, RUN, DRAIN, DONE} state_type;

   state_type                 state_ff;
   logic [3:0]                f_ff, d_ff;
   logic [2:0]                kr_ff, kc_ff;
   logic signed [9:0]         br_ff, bc_ff;
   logic                      drain_ff;
   logic                      ok_ff, run_ff;
   logic                      inb1_ff;
   logic signed [31:0]        prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      rsp_valid_ff, rsp_ok_ff;
   logic signed [31:0]        rsp_result_ff;

   logic                      take, ok_in, inb0, last_pos;
   logic                      rsp_load, rsp_valid_in;
   logic signed [9:0]         ir, ic, br_in, bc_in;
   logic [8:0]                rs, cs;
   logic signed [31:0]        sat;

   assign req.ready = (state_ff == IDLE);
   assign take      = req.valid && req.ready;

   always_comb begin
      case (req.mode)
         MODE_WGT: ok_in = ({1'b0, req.filter_index} < cfg.nfilt) &&
                           ({1'b0, req.channel} < cfg.depth) &&
                           (req.row < {3'd0, cfg.krows}) && (req.col < {3'd0, cfg.kcols});
         MODE_ACT: ok_in = ({1'b0, req.channel} < cfg.depth) &&
                           (req.row < cfg.rows) && (req.col < cfg.cols);
         MODE_RUN: ok_in = ({1'b0, req.filter_index} < cfg.nfilt) &&
                           (req.row < cfg.orows) && (req.col < cfg.ocols);
         default:  ok_in = 1'b0;
      endcase
   end

   // window origin: out * stride - padding
   assign rs    = 9'(req.row * cfg.stride);
   assign cs    = 9'(req.col * cfg.stride);
   assign br_in = $signed({1'b0, rs}) - $signed({8'd0, cfg.pad});
   assign bc_in = $signed({1'b0, cs}) - $signed({8'd0, cfg.pad});

   assign ir   = br_ff + $signed({7'd0, kr_ff});
   assign ic   = bc_ff + $signed({7'd0, kc_ff});
   assign inb0 = (state_ff == RUN) && !ir[9] && !ic[9] &&
                 (ir[8:0] < {3'd0, cfg.rows}) && (ic[8:0] < {3'd0, cfg.cols});

   assign last_pos = ({2'd0, kc_ff} == 5'(cfg.kcols - 3'd1)) &&
                     ({2'd0, kr_ff} == 5'(cfg.krows - 3'd1)) &&
                     ({1'b0, d_ff} == cfg.depth - 5'd1);

   always_comb begin
      mem.wdata = req.value;
      if (state_ff == RUN) begin
         mem.act_we   = 1'b0;
         mem.wgt_we   = 1'b0;
         mem.rd_en    = inb0;
         mem.act_addr = ACT_AW'((d_ff * MAX_SIDE + ir[8:0]) * MAX_SIDE + ic[8:0]);
         mem.wgt_addr = WGT_AW'(((f_ff * MAX_CHANNELS + d_ff) * MAX_KERNEL + kr_ff)
                                * MAX_KERNEL + kc_ff);
      end else begin
         mem.act_we   = take && ok_in && (req.mode == MODE_ACT);
         mem.wgt_we   = take && ok_in && (req.mode == MODE_WGT);
         mem.rd_en    = 1'b0;
         mem.act_addr = ACT_AW'((req.channel * MAX_SIDE + req.row) * MAX_SIDE + req.col);
         mem.wgt_addr = WGT_AW'(((req.filter_index * MAX_CHANNELS + req.channel)
                                * MAX_KERNEL + req.row) * MAX_KERNEL + req.col);
      end
   end

   always_comb begin
      if (acc_ff > $signed(ACC_W'(32'h7fff_ffff)))
         sat = 32'sh7fff_ffff;
      else if (acc_ff < -$signed(ACC_W'(33'h0_8000_0000)))
         sat = 32'sh8000_0000;
      else
         sat = acc_ff[31:0];
   end

   // output register loads when free or drained in the same cycle
   assign rsp_load     = (state_ff == DONE) && (!rsp_valid_ff || rsp.ready);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);

   // MAC pipeline: read, multiply, accumulate
   always_ff @(posedge clock) begin
      inb1_ff <= inb0;
      prod_ff <= inb1_ff ? act_q * wgt_q : 32'sd0;
      if (take)
         acc_ff <= '0;
      else
         acc_ff <= acc_ff + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         drain_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            IDLE: begin
               if (take) begin
                  f_ff   <= req.filter_index;
                  d_ff   <= 4'd0;
                  kr_ff  <= 3'd0;
                  kc_ff  <= 3'd0;
                  br_ff  <= br_in;
                  bc_ff  <= bc_in;
                  ok_ff  <= ok_in;
                  run_ff <= ok_in && (req.mode == MODE_RUN);
                  state_ff <= (ok_in && (req.mode == MODE_RUN)) ? RUN : DONE;
               end
            end
            RUN: begin
               if (last_pos) begin
                  drain_ff <= 1'b0;
                  state_ff <= DRAIN;
               end else if ({2'd0, kc_ff} == 5'(cfg.kcols - 3'd1)) begin
                  kc_ff <= 3'd0;
                  if ({2'd0, kr_ff} == 5'(cfg.krows - 3'd1)) begin
                     kr_ff <= 3'd0;
                     d_ff  <= d_ff + 4'd1;
                  end else begin
                     kr_ff <= kr_ff + 3'd1;
                  end
               end else begin
                  kc_ff <= kc_ff + 3'd1;
               end
            end
            DRAIN: begin
               drain_ff <= 1'b1;
               if (drain_ff)
                  state_ff <= DONE;
            end
            DONE: begin
               if (rsp_load) begin
                  rsp_result_ff <= run_ff ? sat : 32'sd0;
                  rsp_ok_ff     <= ok_ff;
                  state_ff      <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.result   = rsp_result_ff;
   assign rsp.accepted = rsp_ok_ff;

endmodule

FILE: hw/rtl/conv2d_forward_mac_core.sv
// ----------------------------------------------------------------------------
// conv2d_forward_mac_core
// Multichannel 2D convolution engine with on-chip weight and activation stores.
//
//   channel  dir  handshake          payload
//   req_ch   in   valid/ready        mode, filter_index, channel, row, col, value
//   rsp_ch   out  valid/ready        result, accepted
//   csr_*    in   APB write/read     8 registers at 4*i
//
// Writes and rejected requests skip the kernel walk and go from IDLE to DONE.
// Compute: one MAC per cycle, set by the single read port of each store.
// Synchronous reset clears control state and sets the registers to their defaults; the stores hold garbage.
// A stalled result holds in the output register; the next request is taken
// meanwhile and finishes once that register is free.
// ----------------------------------------------------------------------------
module conv2d_forward_mac_core
   import cfm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   cfm_req_if.sink           req_ch,
   cfm_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type            cfg;
   mem_req_type        mem;
   logic signed [15:0] act_q, wgt_q;

   assign csr_pready = 1'b1;

   cfm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   cfm_store u_store (
      .clock (clock),
      .mem   (mem),
      .act_q (act_q),
      .wgt_q (wgt_q)
   );

   cfm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .mem   (mem),
      .act_q (act_q),
      .wgt_q (wgt_q)
   );

endmodule

FILE: hw/rtl/cfm_checker.sv
// ----------------------------------------------------------------------------
// cfm_checker
// Port-level checks of the convolution MAC core, bound to the top level.
// ----------------------------------------------------------------------------
`include "conv2d_forward_mac_core_assert.svh"

module cfm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result,
   input logic        rsp_accepted
);

   `CFM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
   `CFM_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_result), "result changed while stalled")
   `CFM_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "second request taken while busy")
   `CFM_ASSERT(a_reject_zero, clock, reset, rsp_valid && !rsp_accepted |-> rsp_result == 32'd0, "rejected request with nonzero result")
   `CFM_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind conv2d_forward_mac_core cfm_checker u_cfm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_result   (rsp_ch.result),
   .rsp_accepted (rsp_ch.accepted)
);
